// ===== hdl/phme_pkg.sv =====
// Shared types and constants for the plugin header master-name extractor.
package phme_pkg;

    localparam logic [31:0] SIG_FIRST  = 32'h5445_5333;
    localparam logic [31:0] SIG_SECOND = 32'h5445_5334;
    localparam logic [31:0] TYPE_MAST  = 32'h4D41_5354;

    localparam logic [4:0] HDR_LEN_FIRST  = 5'd12;
    localparam logic [4:0] HDR_LEN_SECOND = 5'd20;
    localparam logic [3:0] SUB_HDR_FIRST  = 4'd8;
    localparam logic [3:0] SUB_HDR_SECOND = 4'd6;

    // Result queue depth; must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_COMPLETE     = 2'd0;
    localparam logic [1:0] ST_TRUNCATED    = 2'd1;
    localparam logic [1:0] ST_UNRECOGNIZED = 2'd2;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_HEADER,
        PH_SUBHDR,
        PH_PAYLOAD,
        PH_SKIP,
        PH_TRAIL,
        PH_UNKNOWN
    } phase_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_byte_valid;
        logic       name_end;
        logic       parse_done;
        logic [1:0] parse_status;
    } result_t;

endpackage

// ===== hdl/phme_if.sv =====
// Channel interfaces for file bytes in and name results out.
interface phme_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface phme_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       name_byte_valid;
    logic       name_end;
    logic       parse_done;
    logic [1:0] parse_status;

    modport source (output valid, output name_byte, output name_byte_valid,
                    output name_end, output parse_done, output parse_status,
                    input ready);
    modport sink   (input valid, input name_byte, input name_byte_valid,
                    input name_end, input parse_done, input parse_status,
                    output ready);
endinterface

// ===== hdl/phme_front.sv =====
// Front part: accepts file bytes, walks signature, header and subrecords.
module phme_front
(
    input  logic             clk,
    input  logic             rst_n,
    phme_in_if.sink          file_bytes,
    input  logic             queue_full,
    output logic             push,
    output phme_pkg::result_t push_data
);

    phme_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        layout_reg, layout_next;
    logic [31:0] sig_reg, sig_next;
    logic [31:0] region_size_reg, region_size_next;
    logic [32:0] region_pos_reg, region_pos_next;
    logic [31:0] sub_type_reg, sub_type_next;
    logic [31:0] sub_size_reg, sub_size_next;
    logic [2:0]  sub_cnt_reg, sub_cnt_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic        nul_reg, nul_next;
    logic        master_reg, master_next;

    logic        accept;
    logic [4:0]  hdr_cnt_inc;
    logic [4:0]  hdr_len;
    logic [3:0]  sub_cnt_inc;
    logic [3:0]  sub_len;
    logic [32:0] pos_inc;
    logic [33:0] sub_end;
    logic [31:0] left_dec;
    logic [7:0]  b;
    phme_pkg::result_t res;

    assign b               = file_bytes.data_byte;
    assign file_bytes.ready = !queue_full;
    assign accept          = file_bytes.valid && !queue_full;
    assign hdr_cnt_inc     = hdr_cnt_reg + 5'd1;
    assign hdr_len         = layout_reg ? phme_pkg::HDR_LEN_SECOND : phme_pkg::HDR_LEN_FIRST;
    assign sub_cnt_inc     = {1'b0, sub_cnt_reg} + 4'd1;
    assign sub_len         = layout_reg ? phme_pkg::SUB_HDR_SECOND : phme_pkg::SUB_HDR_FIRST;
    assign pos_inc         = region_pos_reg + 33'd1;
    assign left_dec        = payload_left_reg - 32'd1;
    // Subrecord end, computed without wrap-around.
    assign sub_end         = {1'b0, pos_inc} + {2'b00, sub_size_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= phme_pkg::PH_SIG;
            hdr_cnt_reg      <= '0;
            layout_reg       <= 1'b0;
            sig_reg          <= '0;
            region_size_reg  <= '0;
            region_pos_reg   <= '0;
            sub_type_reg     <= '0;
            sub_size_reg     <= '0;
            sub_cnt_reg      <= '0;
            payload_left_reg <= '0;
            nul_reg          <= 1'b0;
            master_reg       <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            layout_reg       <= layout_next;
            sig_reg          <= sig_next;
            region_size_reg  <= region_size_next;
            region_pos_reg   <= region_pos_next;
            sub_type_reg     <= sub_type_next;
            sub_size_reg     <= sub_size_next;
            sub_cnt_reg      <= sub_cnt_next;
            payload_left_reg <= payload_left_next;
            nul_reg          <= nul_next;
            master_reg       <= master_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        layout_next       = layout_reg;
        sig_next          = sig_reg;
        region_size_next  = region_size_reg;
        region_pos_next   = region_pos_reg;
        sub_type_next     = sub_type_reg;
        sub_size_next     = sub_size_reg;
        sub_cnt_next      = sub_cnt_reg;
        payload_left_next = payload_left_reg;
        nul_next          = nul_reg;
        master_next       = master_reg;
        res               = '0;

        // Assemble the subrecord size one byte at a time, low byte first.
        if (phase_reg == phme_pkg::PH_SUBHDR && sub_cnt_reg[2])
        begin
            sub_size_next = ((sub_cnt_reg[1:0] == 2'd0) ? 32'd0 : sub_size_reg)
                          | ({24'd0, b} << {sub_cnt_reg[1:0], 3'b000});
        end

        if (accept)
        begin
            unique case (phase_reg)
                phme_pkg::PH_SIG:
                begin
                    sig_next = {sig_reg[23:0], b};
                    if (hdr_cnt_inc == 5'd4)
                    begin
                        hdr_cnt_next = '0;
                        if (sig_next == phme_pkg::SIG_FIRST)
                        begin
                            layout_next = 1'b0;
                            phase_next  = phme_pkg::PH_HEADER;
                        end
                        else if (sig_next == phme_pkg::SIG_SECOND)
                        begin
                            layout_next = 1'b1;
                            phase_next  = phme_pkg::PH_HEADER;
                        end
                        else
                        begin
                            phase_next = phme_pkg::PH_UNKNOWN;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_inc;
                    end
                end
                phme_pkg::PH_HEADER:
                begin
                    if (hdr_cnt_reg < 5'd4)
                    begin
                        region_size_next = region_size_reg
                                         | ({24'd0, b} << {hdr_cnt_reg[1:0], 3'b000});
                    end
                    if (hdr_cnt_inc >= hdr_len)
                    begin
                        hdr_cnt_next    = '0;
                        region_pos_next = '0;
                        sub_cnt_next    = '0;
                        phase_next      = (region_size_next == 32'd0) ?
                                          phme_pkg::PH_TRAIL : phme_pkg::PH_SUBHDR;
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_inc;
                    end
                end
                phme_pkg::PH_SUBHDR,
                phme_pkg::PH_PAYLOAD,
                phme_pkg::PH_SKIP:
                begin
                    if (phase_reg == phme_pkg::PH_SUBHDR)
                    begin
                        if (!sub_cnt_reg[2])
                        begin
                            sub_type_next = {sub_type_reg[23:0], b};
                        end
                        if (sub_cnt_inc >= sub_len)
                        begin
                            sub_cnt_next = '0;
                            if (sub_end > {2'b00, region_size_reg})
                            begin
                                phase_next = phme_pkg::PH_SKIP;
                            end
                            else if (sub_size_next != 32'd0)
                            begin
                                payload_left_next = sub_size_next;
                                master_next       = (sub_type_reg == phme_pkg::TYPE_MAST);
                                nul_next          = 1'b0;
                                phase_next        = phme_pkg::PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            sub_cnt_next = sub_cnt_inc[2:0];
                        end
                    end
                    else if (phase_reg == phme_pkg::PH_PAYLOAD)
                    begin
                        if (master_reg)
                        begin
                            if (b == 8'd0)
                            begin
                                nul_next = 1'b1;
                            end
                            else if (!nul_reg)
                            begin
                                res.name_byte       = b;
                                res.name_byte_valid = 1'b1;
                            end
                        end
                        payload_left_next = left_dec;
                        if (left_dec == 32'd0)
                        begin
                            res.name_end = master_reg;
                            master_next  = 1'b0;
                            phase_next   = phme_pkg::PH_SUBHDR;
                        end
                    end
                    region_pos_next = pos_inc;
                    if (pos_inc >= {1'b0, region_size_reg})
                    begin
                        phase_next = phme_pkg::PH_TRAIL;
                    end
                end
                phme_pkg::PH_TRAIL,
                phme_pkg::PH_UNKNOWN:
                begin
                    // drop the byte
                end
                default:
                begin
                    phase_next = phme_pkg::PH_SIG;
                end
            endcase

            if (file_bytes.end_of_file)
            begin
                res.parse_done = 1'b1;
                if (phase_next == phme_pkg::PH_TRAIL)
                    res.parse_status = phme_pkg::ST_COMPLETE;
                else if (phase_next == phme_pkg::PH_UNKNOWN)
                    res.parse_status = phme_pkg::ST_UNRECOGNIZED;
                else
                    res.parse_status = phme_pkg::ST_TRUNCATED;

                // Start the next file from a clean state.
                phase_next        = phme_pkg::PH_SIG;
                hdr_cnt_next      = '0;
                layout_next       = 1'b0;
                sig_next          = '0;
                region_size_next  = '0;
                region_pos_next   = '0;
                sub_type_next     = '0;
                sub_size_next     = '0;
                sub_cnt_next      = '0;
                payload_left_next = '0;
                nul_next          = 1'b0;
                master_next       = 1'b0;
            end
        end
        else
        begin
            sub_size_next = sub_size_reg;
        end
    end

    assign push      = accept && (res.name_byte_valid || res.name_end || res.parse_done);
    assign push_data = res;

endmodule

// ===== hdl/phme_queue.sv =====
// Back part: short result queue whose head drives the output channel.
module phme_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  phme_pkg::result_t push_data,
    output logic              full,
    phme_out_if.source        names
);

    phme_pkg::result_t           mem [phme_pkg::QUEUE_DEPTH];
    logic [phme_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [phme_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [phme_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        pop;
    phme_pkg::result_t           head;

    assign full = (count_reg == (phme_pkg::QPTR_W + 1)'(phme_pkg::QUEUE_DEPTH));
    assign pop  = names.valid && names.ready;
    assign head = mem[rd_ptr_reg];

    assign names.valid           = (count_reg != '0);
    assign names.name_byte       = head.name_byte;
    assign names.name_byte_valid = head.name_byte_valid;
    assign names.name_end        = head.name_end;
    assign names.parse_done      = head.parse_done;
    assign names.parse_status    = head.parse_status;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hdl/plugin_header_master_extractor_top.sv =====
// Results: the result a byte causes is registered in the result queue and offered from its head.
// Throughput: one file byte per cycle; the front stalls only when the result
// queue (two entries) is full because the output side is holding off.
// Reset: rst_n clears the parser to the signature phase and empties the queue.
// After a byte marked end_of_file the parser returns to that state by itself.
module plugin_header_master_extractor_top
(
    input  logic       clk,
    input  logic       rst_n,
    phme_in_if.sink    file_bytes,
    phme_out_if.source names
);

    logic              push;
    logic              full;
    phme_pkg::result_t push_data;

    phme_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_bytes),
        .queue_full (full),
        .push       (push),
        .push_data  (push_data)
    );

    phme_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .names     (names)
    );

endmodule

// ===== hdl/phme_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module phme_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] name_byte,
    input logic       name_byte_valid,
    input logic       name_end,
    input logic       parse_done,
    input logic [1:0] parse_status
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (name_byte_valid || name_end || parse_done))
        else $error("empty result transaction");

    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_done |-> parse_status == phme_pkg::ST_COMPLETE)
        else $error("status set without parse_done");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_done |-> parse_status != 2'd3)
        else $error("undefined status code");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !name_byte_valid |-> name_byte == 8'd0)
        else $error("name_byte set without name_byte_valid");

endmodule

bind plugin_header_master_extractor_top phme_checker u_phme_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (names.valid),
    .out_ready       (names.ready),
    .name_byte       (names.name_byte),
    .name_byte_valid (names.name_byte_valid),
    .name_end        (names.name_end),
    .parse_done      (names.parse_done),
    .parse_status    (names.parse_status)
);

// ===== tb/phme_name_checker.sv =====
// Checker for the master-name extractor: predicts name results per file byte and compares them.
module phme_name_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] name_byte,
    input  logic       name_byte_valid,
    input  logic       name_end,
    input  logic       parse_done,
    input  logic [1:0] parse_status,
    output int         name_pending,
    output int         fail_count
);

    phme_pkg::phase_t  step_phase;
    int unsigned       hdr_count;
    int unsigned       subhdr_count;
    logic              second_layout;
    logic [31:0]       sig_window;
    logic [31:0]       region_len;
    logic [32:0]       region_at;
    logic [31:0]       subrec_type;
    logic [31:0]       subrec_len;
    logic [31:0]       payload_rem;
    logic              nul_hit;
    logic              in_master;

    phme_pkg::result_t expected_names[$];

    initial fail_count = 0;

    task automatic restart_parse();
        step_phase    = phme_pkg::PH_SIG;
        hdr_count     = 0;
        subhdr_count  = 0;
        second_layout = 1'b0;
        sig_window    = '0;
        region_len    = '0;
        region_at     = '0;
        subrec_type   = '0;
        subrec_len    = '0;
        payload_rem   = '0;
        nul_hit       = 1'b0;
        in_master     = 1'b0;
    endtask

    // Advance the parse by one file byte and build the result it causes.
    task automatic parse_file_byte(input logic [7:0] b, input logic last,
                                   output phme_pkg::result_t r, output bit emit);
        int unsigned hdr_len;
        int unsigned sub_len;
        r = '0;
        hdr_len = second_layout ? 32'(phme_pkg::HDR_LEN_SECOND) : 32'(phme_pkg::HDR_LEN_FIRST);
        sub_len = second_layout ? 32'(phme_pkg::SUB_HDR_SECOND) : 32'(phme_pkg::SUB_HDR_FIRST);
        if (step_phase == phme_pkg::PH_SIG)
        begin
            sig_window = {sig_window[23:0], b};
            hdr_count++;
            if (hdr_count == 4)
            begin
                hdr_count = 0;
                if (sig_window == phme_pkg::SIG_FIRST)
                begin
                    second_layout = 1'b0;
                    step_phase    = phme_pkg::PH_HEADER;
                end
                else if (sig_window == phme_pkg::SIG_SECOND)
                begin
                    second_layout = 1'b1;
                    step_phase    = phme_pkg::PH_HEADER;
                end
                else
                begin
                    step_phase = phme_pkg::PH_UNKNOWN;
                end
            end
        end
        else if (step_phase == phme_pkg::PH_HEADER)
        begin
            if (hdr_count < 4)
                region_len = region_len | (32'(b) << (8 * hdr_count));
            hdr_count++;
            if (hdr_count >= hdr_len)
            begin
                hdr_count    = 0;
                region_at    = '0;
                subhdr_count = 0;
                step_phase   = (region_len == 0) ? phme_pkg::PH_TRAIL : phme_pkg::PH_SUBHDR;
            end
        end
        else if (step_phase == phme_pkg::PH_SUBHDR || step_phase == phme_pkg::PH_PAYLOAD
                 || step_phase == phme_pkg::PH_SKIP)
        begin
            if (step_phase == phme_pkg::PH_SUBHDR)
            begin
                if (subhdr_count < 4)
                begin
                    subrec_type = {subrec_type[23:0], b};
                end
                else
                begin
                    if (subhdr_count == 4)
                        subrec_len = '0;
                    subrec_len = subrec_len | (32'(b) << (8 * (subhdr_count - 4)));
                end
                subhdr_count++;
                if (subhdr_count >= sub_len)
                begin
                    subhdr_count = 0;
                    // Compare without wrap-around: an oversized subrecord skips the rest.
                    if (34'(region_at) + 34'd1 + 34'(subrec_len) > 34'(region_len))
                    begin
                        step_phase = phme_pkg::PH_SKIP;
                    end
                    else if (subrec_len != 0)
                    begin
                        payload_rem = subrec_len;
                        in_master   = (subrec_type == phme_pkg::TYPE_MAST);
                        nul_hit     = 1'b0;
                        step_phase  = phme_pkg::PH_PAYLOAD;
                    end
                end
            end
            else if (step_phase == phme_pkg::PH_PAYLOAD)
            begin
                if (in_master)
                begin
                    if (b == 8'h00)
                    begin
                        nul_hit = 1'b1;
                    end
                    else if (!nul_hit)
                    begin
                        r.name_byte       = b;
                        r.name_byte_valid = 1'b1;
                    end
                end
                payload_rem--;
                if (payload_rem == 0)
                begin
                    if (in_master)
                        r.name_end = 1'b1;
                    in_master  = 1'b0;
                    step_phase = phme_pkg::PH_SUBHDR;
                end
            end
            region_at++;
            if (region_at >= {1'b0, region_len})
                step_phase = phme_pkg::PH_TRAIL;
        end

        if (last)
        begin
            r.parse_done = 1'b1;
            if (step_phase == phme_pkg::PH_TRAIL)
                r.parse_status = phme_pkg::ST_COMPLETE;
            else if (step_phase == phme_pkg::PH_UNKNOWN)
                r.parse_status = phme_pkg::ST_UNRECOGNIZED;
            else
                r.parse_status = phme_pkg::ST_TRUNCATED;
        end
        emit = r.name_byte_valid || r.name_end || r.parse_done;
        if (last)
            restart_parse();
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        phme_pkg::result_t got;
        phme_pkg::result_t want;
        phme_pkg::result_t next;
        bit                emit;
        if (!rst_n)
        begin
            restart_parse();
            expected_names.delete();
            name_pending = 0;
        end
        else
        begin
            // Compare the outgoing transaction before predicting from the incoming one.
            if (out_valid && out_ready)
            begin
                got.name_byte       = name_byte;
                got.name_byte_valid = name_byte_valid;
                got.name_end        = name_end;
                got.parse_done      = parse_done;
                got.parse_status    = parse_status;
                if (expected_names.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_names.pop_front();
                    check_field("name_byte", 32'(want.name_byte), 32'(got.name_byte));
                    check_field("name_byte_valid", 32'(want.name_byte_valid),
                                32'(got.name_byte_valid));
                    check_field("name_end", 32'(want.name_end), 32'(got.name_end));
                    check_field("parse_done", 32'(want.parse_done), 32'(got.parse_done));
                    check_field("parse_status", 32'(want.parse_status),
                                32'(got.parse_status));
                end
            end
            if (in_valid && in_ready)
            begin
                parse_file_byte(data_byte, end_of_file, next, emit);
                if (emit)
                    expected_names = {expected_names, next};
            end
            name_pending = expected_names.size();
        end
    end

endmodule

// ===== tb/plugin_header_master_extractor_top_test.sv =====
// Testbench top: feeds plugin files byte by byte and gives the verdict from the checker.
module plugin_header_master_extractor_top_test;

    logic clk = 1'b0;
    logic rst_n;

    phme_in_if  file_if ();
    phme_out_if name_if ();

    int name_pending;
    int fail_count;
    int sent_count = 0;
    int send_pct   = 27;
    int recv_pct   = 48;

    logic [7:0] build_q[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    plugin_header_master_extractor_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_if),
        .names      (name_if)
    );

    phme_name_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (file_if.valid),
        .in_ready        (file_if.ready),
        .data_byte       (file_if.data_byte),
        .end_of_file     (file_if.end_of_file),
        .out_valid       (name_if.valid),
        .out_ready       (name_if.ready),
        .name_byte       (name_if.name_byte),
        .name_byte_valid (name_if.name_byte_valid),
        .name_end        (name_if.name_end),
        .parse_done      (name_if.parse_done),
        .parse_status    (name_if.parse_status),
        .name_pending    (name_pending),
        .fail_count      (fail_count)
    );

    always @(negedge clk)
    begin
        name_if.ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    task automatic put_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            build_q = {build_q, v[8 * k +: 8]};
    endtask

    task automatic put_tag(input logic [31:0] v);
        for (int k = 3; k >= 0; k--)
            build_q = {build_q, v[8 * k +: 8]};
    endtask

    // Send the file in build_q, marking its last byte, one transaction at a time.
    task automatic send_file();
        for (int k = 0; k < build_q.size(); k++)
        begin
            while ($urandom_range(0, 99) < send_pct)
            begin
                file_if.valid <= 1'b0;
                @(negedge clk);
            end
            file_if.valid       <= 1'b1;
            file_if.data_byte   <= build_q[k];
            file_if.end_of_file <= (k == build_q.size() - 1);
            @(posedge clk);
            while (!file_if.ready)
                @(posedge clk);
            @(negedge clk);
            sent_count++;
            if (sent_count < 600)
            begin
                send_pct = 27;
                recv_pct = 48;
            end
            else if (sent_count < 1200)
            begin
                send_pct = 48;
                recv_pct = 27;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end
        end
    endtask

    task automatic build_random_file();
        logic [7:0]  region_q[$];
        logic [31:0] tag;
        logic [31:0] size_field;
        logic [31:0] region_len;
        logic        second;
        int          n_sub;
        int          len;
        int          pick;
        int          cut;
        build_q.delete();
        // Throw in a little random noise now and then; it seldom forms a signature.
        if ($urandom_range(0, 24) == 0)
        begin
            repeat ($urandom_range(1, 10)) build_q = {build_q, 8'($urandom)};
            return;
        end
        second = 1'($urandom_range(0, 1));
        n_sub  = $urandom_range(0, 4);
        for (int s = 0; s < n_sub; s++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                tag = phme_pkg::TYPE_MAST;
            else if (pick < 7)
                tag = phme_pkg::TYPE_MAST ^ (32'h1 << $urandom_range(0, 31));
            else
                tag = $urandom;
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
            size_field = len;
            if ($urandom_range(0, 19) == 0)
                size_field = second ? 32'h0000_FFFF : 32'hFFFF_FFFF;
            put_tag(tag);
            put_le(size_field, second ? 2 : 4);
            for (int j = 0; j < len; j++)
            begin
                if (tag != phme_pkg::TYPE_MAST)
                    build_q = {build_q, 8'($urandom)};
                else if ($urandom_range(0, 9) != 0)
                    build_q = {build_q, 8'($urandom_range(1, 255))};
                else
                    build_q = {build_q, 8'h00};
            end
        end
        // Leave a partial subrecord header at the end of the region.
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, second ? 5 : 7)) build_q = {build_q, 8'($urandom)};
        region_q = build_q;
        build_q.delete();

        region_len = region_q.size();
        pick = $urandom_range(0, 19);
        if (pick == 14 || pick == 15)
            region_len = (region_len > 6) ? region_len - $urandom_range(1, 6) : region_len / 2;
        else if (pick == 16)
            region_len = region_len + $urandom_range(1, 8);
        else if (pick == 17)
            region_len = 32'hFFFF_FFFF;
        else if (pick == 18)
            region_len = 32'h0;
        else if (pick == 19)
            region_len = $urandom;

        tag = second ? phme_pkg::SIG_SECOND : phme_pkg::SIG_FIRST;
        if ($urandom_range(0, 19) == 0)
            tag = tag ^ (32'h1 << $urandom_range(0, 31));
        put_tag(tag);
        put_le(region_len, 4);
        repeat ((second ? 20 : 12) - 4) build_q = {build_q, 8'($urandom)};
        foreach (region_q[k])
            build_q = {build_q, region_q[k]};
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 4)) build_q = {build_q, 8'($urandom)};
        // Cut the file short now and then.
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(1, build_q.size());
            while (build_q.size() > cut)
                void'(build_q.pop_back());
        end
    endtask

    initial
    begin
        file_if.valid       = 1'b0;
        file_if.data_byte   = 8'h00;
        file_if.end_of_file = 1'b0;
        name_if.ready       = 1'b0;
        rst_n               = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // File ending inside its signature.
        build_q.delete();
        build_q = {build_q, 8'h54};
        send_file();
        // Unrecognized signature.
        build_q.delete();
        put_tag(32'h00FF_807F);
        send_file();
        // Empty data region right after a first-layout header.
        build_q.delete();
        put_tag(phme_pkg::SIG_FIRST);
        put_le(32'h0000_0000, 4);
        put_le(32'hFFFF_FFFF, 4);
        put_le(32'h0000_0000, 4);
        send_file();
        // Second-layout file ending before its header.
        build_q.delete();
        put_tag(phme_pkg::SIG_SECOND);
        send_file();

        while (sent_count < 1725)
        begin
            build_random_file();
            send_file();
        end
        file_if.valid <= 1'b0;

        while (name_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/phme_pkg.sv
hdl/phme_if.sv
hdl/phme_front.sv
hdl/phme_queue.sv
hdl/plugin_header_master_extractor_top.sv
hdl/phme_checker.sv
tb/phme_name_checker.sv
tb/plugin_header_master_extractor_top_test.sv
